// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/sfrc_pkg.sv -----
package sfrc_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 17;
  localparam int CFG_W   = 17;
  localparam int INDEX_W = 3;

  localparam logic [COUNT_W-1:0] FIXED_FRAME_RESET = 17'd8;
  localparam logic [COUNT_W-1:0] LAST_OFFSET       = 17'd3;
  localparam logic [COUNT_W-1:0] FRAME_OVERHEAD    = 17'd4;
  localparam logic [COUNT_W-1:0] COUNT_HUNT        = 17'd0;
  localparam logic [COUNT_W-1:0] COUNT_LEN_HIGH    = 17'd1;
  localparam logic [COUNT_W-1:0] COUNT_LEN_LOW     = 17'd2;
  localparam logic [COUNT_W-1:0] COUNT_COMMAND     = 17'd4;
  localparam int CMD_BAD_BIT = 7;

  typedef enum logic [INDEX_W-1:0] {
    REG_STATION_ADDRESS    = 3'd0,
    REG_WRITE_OPCODE       = 3'd1,
    REG_SUM_OPCODE         = 3'd2,
    REG_WRITE_HEADER_BYTES = 3'd3,
    REG_OTHER_HEADER_BYTES = 3'd4,
    REG_FIXED_FRAME_BYTES  = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CMD = 2'd1,
    STATUS_BAD_LEN = 2'd2,
    STATUS_SUM_ERR = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  station_address;
    logic [BYTE_W-1:0]  write_opcode;
    logic [BYTE_W-1:0]  sum_opcode;
    logic [LEN_W-1:0]   write_header_bytes;
    logic [LEN_W-1:0]   other_header_bytes;
    logic [COUNT_W-1:0] fixed_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    status_t           status;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

  typedef struct packed {
    logic res_valid;
    logic hunting;
  } parse_stat_t;

endpackage

// ----- rtl/core/sfrc_cfg.sv -----
module sfrc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfrc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [sfrc_pkg::CFG_W-1:0]    cfg_data,
  output sfrc_pkg::cfg_t                cfg
);
  import sfrc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address    <= '0;
      cfg.write_opcode       <= '0;
      cfg.sum_opcode         <= '0;
      cfg.write_header_bytes <= '0;
      cfg.other_header_bytes <= '0;
      cfg.fixed_frame_bytes  <= FIXED_FRAME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATION_ADDRESS:    cfg.station_address    <= cfg_data[BYTE_W-1:0];
        REG_WRITE_OPCODE:       cfg.write_opcode       <= cfg_data[BYTE_W-1:0];
        REG_SUM_OPCODE:         cfg.sum_opcode         <= cfg_data[BYTE_W-1:0];
        REG_WRITE_HEADER_BYTES: cfg.write_header_bytes <= cfg_data[LEN_W-1:0];
        REG_OTHER_HEADER_BYTES: cfg.other_header_bytes <= cfg_data[LEN_W-1:0];
        REG_FIXED_FRAME_BYTES:  cfg.fixed_frame_bytes  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sfrc_parser.sv -----
module sfrc_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [sfrc_pkg::BYTE_W-1:0]  rx_byte,
  input  sfrc_pkg::cfg_t               cfg,
  output sfrc_pkg::parse_stat_t        stat,
  output sfrc_pkg::result_t            res
);
  import sfrc_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0]  length_high, length_high_next;
  logic [LEN_W-1:0]   frame_length, frame_length_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0]  command_byte, command_byte_next;

  logic [COUNT_W-1:0] last;
  logic [COUNT_W-1:0] frame_size;
  logic [LEN_W-1:0]   hdr;
  logic               in_body;
  logic               is_end;
  status_t            status_calc;

  assign last       = {1'b0, frame_length} + LAST_OFFSET;
  assign frame_size = {1'b0, frame_length} + FRAME_OVERHEAD;
  assign in_body    = byte_count < last;
  assign is_end     = (byte_count != COUNT_HUNT) && (byte_count != COUNT_LEN_HIGH) &&
                      (byte_count != COUNT_LEN_LOW) && !in_body;

  // later checks override earlier ones
  always_comb begin
    status_calc = STATUS_OK;
    if (command_byte[CMD_BAD_BIT]) begin
      status_calc = STATUS_BAD_CMD;
    end
    if (command_byte != cfg.write_opcode && command_byte != cfg.sum_opcode &&
        frame_size != cfg.fixed_frame_bytes) begin
      status_calc = STATUS_BAD_LEN;
    end
    if (running_sum != rx_byte) begin
      status_calc = STATUS_SUM_ERR;
    end
  end

  assign hdr = (command_byte == cfg.write_opcode) ? cfg.write_header_bytes
                                                  : cfg.other_header_bytes;

  assign res.command        = command_byte;
  assign res.status         = status_calc;
  assign res.payload_length = frame_length - hdr;

  assign stat.res_valid = accept && is_end;
  assign stat.hunting   = (byte_count == COUNT_HUNT);

  always_comb begin
    byte_count_next   = byte_count;
    length_high_next  = length_high;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    command_byte_next = command_byte;
    if (accept) begin
      if (byte_count == COUNT_HUNT) begin
        if (rx_byte == cfg.station_address) begin
          byte_count_next   = COUNT_LEN_HIGH;
          length_high_next  = '0;
          frame_length_next = '0;
          running_sum_next  = '0;
          command_byte_next = '0;
        end
      end else if (byte_count == COUNT_LEN_HIGH) begin
        length_high_next = rx_byte;
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = COUNT_LEN_LOW;
      end else if (byte_count == COUNT_LEN_LOW) begin
        frame_length_next = {length_high, rx_byte};
        running_sum_next  = running_sum + rx_byte;
        byte_count_next   = byte_count + 17'd1;
      end else if (in_body) begin
        if (byte_count == COUNT_COMMAND) begin
          command_byte_next = rx_byte;
        end
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = byte_count + 17'd1;
      end else begin
        // checksum byte closes the frame
        byte_count_next   = COUNT_HUNT;
        length_high_next  = '0;
        frame_length_next = '0;
        running_sum_next  = '0;
        command_byte_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= COUNT_HUNT;
      length_high  <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      command_byte <= '0;
    end else begin
      byte_count   <= byte_count_next;
      length_high  <= length_high_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      command_byte <= command_byte_next;
    end
  end

endmodule

// ----- rtl/core/sfrc_out_reg.sv -----
module sfrc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sfrc_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output sfrc_pkg::result_t res_q
);
  import sfrc_pkg::*;

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

// ----- rtl/core/serial_frame_receiver_checker_top.sv -----
// a frame result shows on the outputs in the cycle after its checksum byte is accepted
// throughput: one byte per cycle; bytes stall only while a result sits unread in the output register
// the output register is the only stage; frame state updates in the cycle a byte is accepted
// reset: synchronous; frame state returns to address hunting, output drops valid,
// config registers go to zero except fixed_frame_bytes, which resets to 8
`include "assert_macros.svh"

module serial_frame_receiver_checker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfrc_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfrc_pkg::BYTE_W-1:0]   command,
  output logic [1:0]                    status,
  output logic [sfrc_pkg::LEN_W-1:0]    payload_length,
  input  logic                          cfg_we,
  input  logic [sfrc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [sfrc_pkg::CFG_W-1:0]    cfg_data
);
  import sfrc_pkg::*;

  cfg_t        cfg;
  parse_stat_t stat;
  result_t     res;
  result_t     res_q;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  sfrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfrc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .stat    (stat),
    .res     (res)
  );

  sfrc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (stat.res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign command        = res_q.command;
  assign status         = res_q.status;
  assign payload_length = res_q.payload_length;

  // a result only comes from an accepted byte, never while hunting
  `ASSERT_SAME(a_res_from_frame, clk, rst, stat.res_valid, accept && !stat.hunting)
  // a closed frame lands in the output register
  `ASSERT_NEXT(a_res_lands, clk, rst, stat.res_valid, out_valid)
  // the frame state goes back to hunting after the checksum byte
  `ASSERT_NEXT(a_back_to_hunt, clk, rst, stat.res_valid, stat.hunting)

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int          RANDOM_BYTES   = 620;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          IDLE_PCT       = 28;
  localparam int          REPORT_MAX     = 10;
  localparam int          REG_SPARE_FIRST = 6;
  localparam int          REG_SPARE_LAST  = 7;

  typedef struct {
    int          cfg_sel;
    int          noise;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [7:0]  sum_delta;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte        = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [BYTE_W-1:0]   command;
  logic [1:0]          status;
  logic [LEN_W-1:0]    payload_length;
  logic                cfg_we         = 1'b0;
  logic [INDEX_W-1:0]  cfg_index      = '0;
  logic [CFG_W-1:0]    cfg_data       = '0;

  // frame parser mirror
  cfg_t                cfg_mirror = '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, FIXED_FRAME_RESET};
  logic [COUNT_W-1:0]  frm_count  = COUNT_HUNT;
  logic [BYTE_W-1:0]   frm_len_hi = '0;
  logic [LEN_W-1:0]    frm_len    = '0;
  logic [BYTE_W-1:0]   frm_sum    = '0;
  logic [BYTE_W-1:0]   frm_cmd    = '0;

  result_t             due_results [$];
  int                  fail_count = 0;
  int                  sent_bytes = 0;
  int unsigned         cycles     = 0;
  bit                  no_idle    = 1'b0;
  bit                  hold_req   = 1'b0;

  cfg_t cfg_sets [0:3] = '{
    '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, FIXED_FRAME_RESET},
    '{8'hFF, 8'h81, 8'h42, 16'hFFFF, 16'h0001, 17'h1FFFF},
    '{8'h7E, 8'h10, 8'h10, 16'h0003, 16'h0002, 17'd65539},
    '{8'h55, 8'h01, 8'h02, 16'h0000, 16'hFFFF, 17'd0}
  };

  frame_row_t frame_rows [0:17] = '{
    '{0, 0, 16'd0, 8'h00, 8'h00, 1'b1, '{8'h00, STATUS_OK,      16'd0}},
    '{0, 0, 16'd1, 8'h00, 8'h00, 1'b1, '{8'h00, STATUS_OK,      16'd1}},
    '{0, 0, 16'd4, 8'h80, 8'h00, 1'b1, '{8'h80, STATUS_BAD_CMD, 16'd4}},
    '{0, 3, 16'd4, 8'h05, 8'h00, 1'b0, '{8'h00, STATUS_OK,      16'd0}},
    '{0, 0, 16'd5, 8'h05, 8'h00, 1'b1, '{8'h05, STATUS_BAD_LEN, 16'd5}},
    '{0, 0, 16'd5, 8'hFF, 8'h00, 1'b0, '{8'h00, STATUS_OK,      16'd0}},
    '{0, 0, 16'd4, 8'h7F, 8'h01, 1'b1, '{8'h7F, STATUS_SUM_ERR, 16'd4}},
    '{0, 0, 16'd2, 8'h00, 8'h80, 1'b1, '{8'h00, STATUS_SUM_ERR, 16'd2}},
    '{1, 0, 16'd0, 8'h00, 8'h00, 1'b1, '{8'h00, STATUS_BAD_LEN, 16'hFFFF}},
    '{1, 0, 16'd3, 8'h81, 8'h00, 1'b1, '{8'h81, STATUS_BAD_CMD, 16'd4}},
    '{1, 2, 16'd3, 8'h42, 8'h00, 1'b1, '{8'h42, STATUS_OK,      16'd2}},
    '{1, 0, 16'd3, 8'hC2, 8'h01, 1'b1, '{8'hC2, STATUS_SUM_ERR, 16'd2}},
    '{2, 0, 16'd6, 8'h10, 8'h00, 1'b1, '{8'h10, STATUS_OK,      16'd3}},
    '{2, 0, 16'd2, 8'h11, 8'h00, 1'b1, '{8'h11, STATUS_BAD_LEN, 16'd0}},
    '{2, 2, 16'd5, 8'h90, 8'h00, 1'b0, '{8'h00, STATUS_OK,      16'd0}},
    '{3, 1, 16'd4, 8'h02, 8'h00, 1'b1, '{8'h02, STATUS_OK,      16'd5}},
    '{3, 0, 16'd4, 8'h03, 8'h00, 1'b1, '{8'h03, STATUS_BAD_LEN, 16'd5}},
    '{3, 0, 16'd1, 8'h00, 8'h00, 1'b1, '{8'h00, STATUS_BAD_LEN, 16'd2}}
  };

  serial_frame_receiver_checker_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .status         (status),
    .payload_length (payload_length),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic clear_frame();
    frm_count  = COUNT_HUNT;
    frm_len_hi = '0;
    frm_len    = '0;
    frm_sum    = '0;
    frm_cmd    = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, output bit done, output result_t r);
    logic [LEN_W-1:0] hdr;
    done = 1'b0;
    r    = '{8'h00, STATUS_OK, 16'h0000};
    if (frm_count == COUNT_HUNT) begin
      if (b == cfg_mirror.station_address) begin
        clear_frame();
        frm_count = COUNT_LEN_HIGH;
      end
    end else if (frm_count == COUNT_LEN_HIGH) begin
      frm_len_hi = b;
      frm_sum    = frm_sum + b;
      frm_count  = frm_count + 1'b1;
    end else if (frm_count == COUNT_LEN_LOW) begin
      frm_len   = {frm_len_hi, b};
      frm_sum   = frm_sum + b;
      frm_count = frm_count + 1'b1;
    end else if (frm_count < {1'b0, frm_len} + LAST_OFFSET) begin
      if (frm_count == COUNT_COMMAND) begin
        frm_cmd = b;
      end
      frm_sum   = frm_sum + b;
      frm_count = frm_count + 1'b1;
    end else begin
      // checksum byte closes the frame
      r.command = frm_cmd;
      if (frm_cmd[CMD_BAD_BIT]) begin
        r.status = STATUS_BAD_CMD;
      end
      if (frm_cmd != cfg_mirror.write_opcode && frm_cmd != cfg_mirror.sum_opcode &&
          ({1'b0, frm_len} + FRAME_OVERHEAD) != cfg_mirror.fixed_frame_bytes) begin
        r.status = STATUS_BAD_LEN;
      end
      if (frm_sum != b) begin
        r.status = STATUS_SUM_ERR;
      end
      hdr = (frm_cmd == cfg_mirror.write_opcode) ? cfg_mirror.write_header_bytes
                                                 : cfg_mirror.other_header_bytes;
      r.payload_length = frm_len - hdr;
      done = 1'b1;
      clear_frame();
    end
  endtask

  // one byte transaction on the input channel
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    bit      done;
    result_t r;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b, done, r);
    if (done) begin
      due_results.push_back(typed ? want : r);
    end
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == cfg_mirror.station_address);
      send_byte(b, 1'b0, '{8'h00, STATUS_OK, 16'h0000});
    end
  endtask

  // cut below the full size leaves the frame open; it is then closed with random bytes
  task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
                            input logic [7:0] sum_delta, input int cut,
                            input bit typed, input result_t want);
    logic [7:0] sum;
    logic [7:0] b;
    int         last;
    sum  = '0;
    last = int'(len) + 3;
    for (int k = 0; k <= last && k < cut; k++) begin
      if (k == 0) begin
        b = cfg_mirror.station_address;
      end else if (k == 1) begin
        b = len[15:8];
      end else if (k == 2) begin
        b = len[7:0];
      end else if (k < last) begin
        b = (k == 4) ? cmd : 8'($urandom);
      end else begin
        b = sum + sum_delta;
      end
      if (k > 0 && k < last) begin
        sum = sum + b;
      end
      send_byte(b, typed && k == last, want);
    end
    while (frm_count != COUNT_HUNT) begin
      send_byte(8'($urandom), 1'b0, want);
    end
  endtask

  task automatic send_random_frame();
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [7:0]  delta;
    int          pick;
    int          cut;
    if ($urandom_range(0, 99) < 10) begin
      send_noise($urandom_range(1, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = 16'($urandom_range(0, 8));
    end else if (pick < 97) begin
      if (cfg_mirror.fixed_frame_bytes >= FRAME_OVERHEAD &&
          cfg_mirror.fixed_frame_bytes <= FRAME_OVERHEAD + 17'd12) begin
        len = 16'(cfg_mirror.fixed_frame_bytes - FRAME_OVERHEAD);
      end else begin
        len = 16'($urandom_range(0, 12));
      end
    end else begin
      len = 16'($urandom_range(256, 280));
    end
    case ($urandom_range(0, 3))
      0: cmd = cfg_mirror.write_opcode;
      1: cmd = cfg_mirror.sum_opcode;
      2: cmd = 8'($urandom_range(0, 127));
      default: cmd = 8'($urandom_range(128, 255));
    endcase
    delta = ($urandom_range(0, 99) < 80) ? 8'h00 : 8'($urandom_range(1, 255));
    cut   = int'(len) + 4;
    if (len != 0 && $urandom_range(0, 99) < 8) begin
      cut = $urandom_range(3, int'(len) + 2);
    end
    send_frame(len, cmd, delta, cut, 1'b0, '{8'h00, STATUS_OK, 16'h0000});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_cfg(input cfg_t c);
    logic [INDEX_W-1:0] idx  [0:6];
    logic [CFG_W-1:0]   data [0:6];
    idx[0]  = REG_STATION_ADDRESS;
    idx[1]  = REG_WRITE_OPCODE;
    idx[2]  = REG_SUM_OPCODE;
    idx[3]  = REG_WRITE_HEADER_BYTES;
    idx[4]  = REG_OTHER_HEADER_BYTES;
    idx[5]  = REG_FIXED_FRAME_BYTES;
    idx[6]  = INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
    // junk in the upper bits must be dropped
    data[0] = {9'($urandom), c.station_address};
    data[1] = {9'($urandom), c.write_opcode};
    data[2] = {9'($urandom), c.sum_opcode};
    data[3] = {1'($urandom), c.write_header_bytes};
    data[4] = {1'($urandom), c.other_header_bytes};
    data[5] = c.fixed_frame_bytes;
    data[6] = CFG_W'($urandom);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg_mirror.station_address    = data[0][BYTE_W-1:0];
    cfg_mirror.write_opcode       = data[1][BYTE_W-1:0];
    cfg_mirror.sum_opcode         = data[2][BYTE_W-1:0];
    cfg_mirror.write_header_bytes = data[3][LEN_W-1:0];
    cfg_mirror.other_header_bytes = data[4][LEN_W-1:0];
    cfg_mirror.fixed_frame_bytes  = data[5];
  endtask

  function automatic logic [15:0] random_header();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.station_address    = 8'($urandom);
    c.write_opcode       = 8'($urandom);
    c.sum_opcode         = ($urandom_range(0, 3) == 0) ? c.write_opcode : 8'($urandom);
    c.write_header_bytes = random_header();
    c.other_header_bytes = random_header();
    case ($urandom_range(0, 5))
      0: c.fixed_frame_bytes = 17'd0;
      1: c.fixed_frame_bytes = 17'd65539;
      2: c.fixed_frame_bytes = 17'h1FFFF;
      3: c.fixed_frame_bytes = 17'($urandom);
      default: c.fixed_frame_bytes = 17'($urandom_range(4, 16));
    endcase
    return c;
  endfunction

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected frame result: cmd %h status %0d len %h",
                   command, status, payload_length);
        end
      end else begin
        want = due_results.pop_front();
        if (command !== want.command || status !== want.status ||
            payload_length !== want.payload_length) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("frame result mismatch: expected cmd %h status %0d len %h, ",
                     want.command, want.status, want.payload_length,
                     "got cmd %h status %0d len %h",
                     command, status, payload_length);
          end
        end
      end
    end
  end

  initial begin
    int          cur_set;
    int          start;
    bit          hold_done;
    cur_set   = 0;
    hold_done = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (frame_rows[i]) begin
      if (frame_rows[i].cfg_sel != cur_set) begin
        wait_drained();
        program_cfg(cfg_sets[frame_rows[i].cfg_sel]);
        cur_set = frame_rows[i].cfg_sel;
      end
      send_noise(frame_rows[i].noise);
      send_frame(frame_rows[i].len, frame_rows[i].cmd, frame_rows[i].sum_delta,
                 int'(frame_rows[i].len) + 4, frame_rows[i].typed, frame_rows[i].want);
    end

    wait_drained();
    program_cfg(random_cfg());
    start = sent_bytes;
    while (sent_bytes - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 14) == 0) begin
        wait_drained();
        program_cfg(random_cfg());
      end
      if (!hold_done && sent_bytes - start >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      no_idle = (sent_bytes - start >= 350) && (sent_bytes - start < 500);
      send_random_frame();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
